// ===== design/escape_time_fractal_iterator_defines.svh =====
// Assertion macros used by the escape-time iterator design file.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define ETF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define ETF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== design/etf_pkg.sv =====
// Shared types, constants and saturation helpers of the escape-time iterator.
`default_nettype none

package etf_pkg;

	// Fixed widths of the datapath and the ports.
	localparam int FX_W       = 32;
	localparam int PROD_W     = 64;
	localparam int STEP_W     = 31;
	localparam int COORD_W    = 10;
	localparam int ITER_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [FX_W-1:0] FX_MAX = 32'sh7fffffff;
	localparam logic signed [FX_W-1:0] FX_MIN = 32'sh80000000;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUBIC       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd5;

	// Register values after reset.
	localparam logic [ITER_W-1:0]      RST_MAX_ITER    = 12'd100;
	localparam logic                   RST_CUBIC       = 1'b0;
	localparam logic signed [FX_W-1:0] RST_REAL_ORIGIN = -32'sd295279002;
	localparam logic signed [FX_W-1:0] RST_IMAG_ORIGIN = -32'sd228170138;
	localparam logic [STEP_W-1:0]      RST_REAL_STEP   = 31'd456340;
	localparam logic [STEP_W-1:0]      RST_IMAG_STEP   = 31'd456340;

	// Configuration register file contents.
	typedef struct packed {
		logic [ITER_W-1:0]      max_iterations;
		logic                   cubic_mode;
		logic signed [FX_W-1:0] real_origin;
		logic signed [FX_W-1:0] imag_origin;
		logic [STEP_W-1:0]      real_step;
		logic [STEP_W-1:0]      imag_step;
	} cfg_t;

	// Clamp a wide signed value to the fixed-point word range.
	function automatic logic signed [FX_W-1:0] sat_wide(input logic signed [PROD_W-1:0] v);
		logic signed [FX_W-1:0] r;
		if (v > PROD_W'(FX_MAX)) begin
			r = FX_MAX;
		end else if (v < PROD_W'(FX_MIN)) begin
			r = FX_MIN;
		end else begin
			r = v[FX_W-1:0];
		end
		return r;
	endfunction

	// Saturating sum of two words.
	function automatic logic signed [FX_W-1:0] sat_add(input logic signed [FX_W-1:0] a,
		input logic signed [FX_W-1:0] b);
		logic signed [FX_W:0] s;
		logic signed [FX_W-1:0] r;
		s = {a[FX_W-1], a} + {b[FX_W-1], b};
		if (s[FX_W] != s[FX_W-1]) begin
			r = s[FX_W] ? FX_MIN : FX_MAX;
		end else begin
			r = s[FX_W-1:0];
		end
		return r;
	endfunction

	// Saturating difference of two words.
	function automatic logic signed [FX_W-1:0] sat_sub(input logic signed [FX_W-1:0] a,
		input logic signed [FX_W-1:0] b);
		logic signed [FX_W:0] s;
		logic signed [FX_W-1:0] r;
		s = {a[FX_W-1], a} - {b[FX_W-1], b};
		if (s[FX_W] != s[FX_W-1]) begin
			r = s[FX_W] ? FX_MIN : FX_MAX;
		end else begin
			r = s[FX_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/etf_cfg_regs.sv =====
// Configuration register file of the escape-time iterator.
`default_nettype none

module etf_cfg_regs import etf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Decode the write index; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iterations <= RST_MAX_ITER;
			cfg_q.cubic_mode     <= RST_CUBIC;
			cfg_q.real_origin    <= RST_REAL_ORIGIN;
			cfg_q.imag_origin    <= RST_IMAG_ORIGIN;
			cfg_q.real_step      <= RST_REAL_STEP;
			cfg_q.imag_step      <= RST_IMAG_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_ITER:    cfg_q.max_iterations <= cfg_wdata[ITER_W-1:0];
				REG_CUBIC:       cfg_q.cubic_mode     <= cfg_wdata[0];
				REG_REAL_ORIGIN: cfg_q.real_origin    <= signed'(cfg_wdata[FX_W-1:0]);
				REG_IMAG_ORIGIN: cfg_q.imag_origin    <= signed'(cfg_wdata[FX_W-1:0]);
				REG_REAL_STEP:   cfg_q.real_step      <= cfg_wdata[STEP_W-1:0];
				REG_IMAG_STEP:   cfg_q.imag_step      <= cfg_wdata[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/etf_mul_unit.sv =====
// Shared signed multiplier with registered product and fixed-point rescale.
`default_nettype none

module etf_mul_unit import etf_pkg::*; #(
	parameter int FRACTION_BITS = 27
) (
	input  wire logic                    clk,
	input  wire logic signed [FX_W-1:0]  op_a,
	input  wire logic signed [FX_W-1:0]  op_b,
	output logic signed [PROD_W-1:0]     prod,
	output logic signed [FX_W-1:0]       prod_fx
);

	logic signed [PROD_W-1:0] prod_s1;

	// One full-precision product per cycle.
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	// Arithmetic shift rounds toward minus infinity, then clamp to the word.
	assign prod    = prod_s1;
	assign prod_fx = sat_wide(prod_s1 >>> FRACTION_BITS);

endmodule

`default_nettype wire

// ===== design/escape_time_fractal_iterator.sv =====
// The one shared 32x32 multiplier gives one product per cycle; each round of
// z^2+c needs three of them and each round of z^3+c needs seven.
// One pixel at a time: the next word is taken only in idle, after the result is stored.
// A finished result waits in the output register while the next pixel is accepted.
// Asynchronous active-low reset returns the sequencer to idle and loads register defaults.
`default_nettype none

module escape_time_fractal_iterator import etf_pkg::*; #(
	parameter int MAX_COLUMNS   = 1024,
	parameter int MAX_ROWS      = 1024,
	parameter int FRACTION_BITS = 27,
	parameter int COUNT_BITS    = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_W-1:0]    pixel_column,
	input  wire logic [COORD_W-1:0]    pixel_row,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [ITER_W-1:0]          iteration_count
);

	`include "escape_time_fractal_iterator_defines.svh"

	localparam int IDX_CMP_W = 17;
	localparam int COL_LAST  = MAX_COLUMNS - 1;
	localparam int ROW_LAST  = MAX_ROWS - 1;
	localparam int COUNT_CAP = (1 << COUNT_BITS) - 1;
	localparam int ESC_SH    = 2 * FRACTION_BITS + 2;
	localparam logic ESC_ON  = (ESC_SH < PROD_W);
	localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(1) << (ESC_ON ? ESC_SH : 0);

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_CRE  = 14'b00000000000010,
		S_CIM  = 14'b00000000000100,
		S_PT   = 14'b00000000001000,
		S_RR   = 14'b00000000010000,
		S_II   = 14'b00000000100000,
		S_TST  = 14'b00000001000000,
		S_RI   = 14'b00000010000000,
		S_C2   = 14'b00000100000000,
		S_C3   = 14'b00001000000000,
		S_C4   = 14'b00010000000000,
		S_C5   = 14'b00100000000000,
		S_UPD  = 14'b01000000000000,
		S_DONE = 14'b10000000000000
	} state_t;

	cfg_t cfg;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic [ITER_W-1:0] out_count_q;

	logic [COORD_W-1:0]     col_q, row_q;
	logic [ITER_W-1:0]      limit_q, n_q;
	logic signed [FX_W-1:0] zr_q, zi_q, cr_q, ci_q;
	logic signed [FX_W-1:0] sr_q, si_q, acc_q;
	logic [PROD_W-1:0]      rr_q;

	logic signed [FX_W-1:0]   op_a, op_b, prod_fx;
	logic signed [PROD_W-1:0] prod;

	logic               accept, out_free, done;
	logic [PROD_W-1:0]  mag;
	logic signed [FX_W-1:0] si_sq;
	logic [COORD_W-1:0] col_in, row_in;
	logic [ITER_W-1:0]  limit_in;

	etf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	etf_mul_unit #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod    (prod),
		.prod_fx (prod_fx)
	);

	// Handshake and input conditioning: clamp indexes and the iteration limit.
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign col_in = (IDX_CMP_W'(pixel_column) >= IDX_CMP_W'(MAX_COLUMNS)) ?
		COORD_W'(COL_LAST) : pixel_column;
	assign row_in = (IDX_CMP_W'(pixel_row) >= IDX_CMP_W'(MAX_ROWS)) ?
		COORD_W'(ROW_LAST) : pixel_row;
	assign limit_in = (IDX_CMP_W'(cfg.max_iterations) > IDX_CMP_W'(COUNT_CAP)) ?
		ITER_W'(COUNT_CAP) : cfg.max_iterations;

	// Escape test on the exact squares, plus the iteration limit.
	assign mag   = rr_q + unsigned'(prod);
	assign done  = (ESC_ON && (mag >= ESC_LIMIT)) || (n_q >= limit_q);
	assign si_sq = sat_add(prod_fx, prod_fx);

	// Multiplier operand selection for the product issued in each state.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_CRE: begin
				op_a = signed'({{(FX_W-COORD_W){1'b0}}, col_q});
				op_b = signed'({{(FX_W-STEP_W){1'b0}}, cfg.real_step});
			end
			S_CIM: begin
				op_a = signed'({{(FX_W-COORD_W){1'b0}}, row_q});
				op_b = signed'({{(FX_W-STEP_W){1'b0}}, cfg.imag_step});
			end
			S_RR: begin
				op_a = zr_q;
				op_b = zr_q;
			end
			S_II: begin
				op_a = zi_q;
				op_b = zi_q;
			end
			S_TST: begin
				op_a = zr_q;
				op_b = zi_q;
			end
			S_RI: begin
				op_a = sr_q;
				op_b = zr_q;
			end
			S_C2: begin
				op_a = si_q;
				op_b = zi_q;
			end
			S_C3: begin
				op_a = sr_q;
				op_b = zi_q;
			end
			S_C4: begin
				op_a = si_q;
				op_b = zr_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_CRE;
			S_CRE:  state_d = S_CIM;
			S_CIM:  state_d = S_PT;
			S_PT:   state_d = S_RR;
			S_RR:   state_d = S_II;
			S_II:   state_d = S_TST;
			S_TST:  state_d = done ? S_DONE : S_RI;
			S_RI:   state_d = cfg.cubic_mode ? S_C2 : S_RR;
			S_C2:   state_d = S_C3;
			S_C3:   state_d = S_C4;
			S_C4:   state_d = S_C5;
			S_C5:   state_d = S_UPD;
			S_UPD:  state_d = S_RR;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control state and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; those fed by a product are loaded in the state that consumes it.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					col_q   <= col_in;
					row_q   <= row_in;
					limit_q <= limit_in;
					n_q     <= '0;
					zr_q    <= '0;
					zi_q    <= '0;
				end
			end
			S_CIM: cr_q <= sat_wide(PROD_W'(cfg.real_origin) + prod);
			S_PT:  ci_q <= sat_wide(PROD_W'(cfg.imag_origin) + prod);
			S_II: begin
				rr_q  <= unsigned'(prod);
				acc_q <= prod_fx;
			end
			S_TST: sr_q <= sat_sub(acc_q, prod_fx);
			S_RI: begin
				if (cfg.cubic_mode) begin
					si_q <= si_sq;
				end else begin
					zr_q <= sat_add(sr_q, cr_q);
					zi_q <= sat_add(si_sq, ci_q);
					n_q  <= n_q + 1'b1;
				end
			end
			S_C2: acc_q <= prod_fx;
			S_C3: sr_q  <= sat_sub(acc_q, prod_fx);
			S_C4: acc_q <= prod_fx;
			S_C5: si_q  <= sat_add(acc_q, prod_fx);
			S_UPD: begin
				zr_q <= sat_add(sr_q, cr_q);
				zi_q <= sat_add(si_q, ci_q);
				n_q  <= n_q + 1'b1;
			end
			S_DONE: if (out_free) out_count_q <= n_q;
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign iteration_count = out_count_q;

	// A taken word keeps the block busy in the following cycle.
	`ETF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// The round count never passes the clamped limit while a pixel is in work.
	`ETF_ASSERT_NOW(a_count_in_limit, state_q != S_IDLE && state_q != S_CRE, n_q <= limit_q)
	// Storing a result raises valid with the count reached by the sequencer.
	`ETF_ASSERT_NEXT(a_result_stored, state_q == S_DONE && out_free,
		out_valid && iteration_count == $past(n_q))

endmodule

`default_nettype wire

// ===== bench/escape_time_fractal_iterator_checker.sv =====
// Monitor that predicts each pixel's escape count and compares it with the iterator's results.
module escape_time_fractal_iterator_checker import etf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [COORD_W-1:0]    pixel_column,
	input  logic [COORD_W-1:0]    pixel_row,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [ITER_W-1:0]     iteration_count,
	output int                    outstanding,
	output int                    failures,
	output int                    results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_COLUMNS   = 1024;
	localparam int MAX_ROWS      = 1024;
	localparam int FRACTION_BITS = 27;
	localparam int COUNT_BITS    = 12;

	// |z|^2 bound of 4.0 at the doubled fraction precision of an exact square.
	localparam logic [63:0] RADIUS_SQ = 64'd1 << (2 * FRACTION_BITS + 2);

	typedef struct {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [ITER_W-1:0]  count;
	} pixel_count_t;

	pixel_count_t expected_counts[$];
	pixel_count_t incoming;
	pixel_count_t oldest;
	cfg_t         view;
	int           error_total;
	int           checked_total;

	// Clamp a wide value to the signed 32-bit word range.
	function automatic longint clamp_word(input longint v);
		longint r;
		r = v;
		if (v > longint'(FX_MAX)) begin
			r = longint'(FX_MAX);
		end else if (v < longint'(FX_MIN)) begin
			r = longint'(FX_MIN);
		end
		return r;
	endfunction

	// Exact product, floored back to the word's fraction, then saturated.
	function automatic longint fixed_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return clamp_word(p >>> FRACTION_BITS);
	endfunction

	function automatic void complex_product(input longint ar, input longint ai,
		input longint br, input longint bi, output longint pr, output longint pi);
		pr = clamp_word(fixed_mul(ar, br) - fixed_mul(ai, bi));
		pi = clamp_word(fixed_mul(ar, bi) + fixed_mul(ai, br));
	endfunction

	// Number of rounds of z = z^2 + c (or z^3 + c) before escape or the limit.
	function automatic logic [ITER_W-1:0] escape_count(input cfg_t v,
		input logic [COORD_W-1:0] column, input logic [COORD_W-1:0] row);
		longint      col_i, row_i, cr, ci, zr, zi, sr, si, tr, ti;
		logic [63:0] re_sq, im_sq;
		int unsigned limit, rounds;
		col_i = longint'(column);
		row_i = longint'(row);
		if (col_i >= MAX_COLUMNS) col_i = longint'(MAX_COLUMNS - 1);
		if (row_i >= MAX_ROWS) row_i = longint'(MAX_ROWS - 1);
		limit = 32'(v.max_iterations);
		if (limit > (1 << COUNT_BITS) - 1) limit = (1 << COUNT_BITS) - 1;
		cr = clamp_word(longint'(signed'(v.real_origin)) + col_i * longint'(v.real_step));
		ci = clamp_word(longint'(signed'(v.imag_origin)) + row_i * longint'(v.imag_step));
		zr = 0;
		zi = 0;
		rounds = 0;
		forever begin
			re_sq = zr * zr;
			im_sq = zi * zi;
			if (re_sq + im_sq >= RADIUS_SQ || rounds >= limit) break;
			complex_product(zr, zi, zr, zi, sr, si);
			if (v.cubic_mode) begin
				complex_product(sr, si, zr, zi, tr, ti);
				sr = tr;
				si = ti;
			end
			zr = clamp_word(sr + cr);
			zi = clamp_word(si + ci);
			rounds++;
		end
		return rounds[ITER_W-1:0];
	endfunction

	// Track register writes, queue a prediction per accepted pixel, check each result word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view.max_iterations = RST_MAX_ITER;
			view.cubic_mode     = RST_CUBIC;
			view.real_origin    = RST_REAL_ORIGIN;
			view.imag_origin    = RST_IMAG_ORIGIN;
			view.real_step      = RST_REAL_STEP;
			view.imag_step      = RST_IMAG_STEP;
			expected_counts.delete();
			error_total = 0;
			checked_total = 0;
			outstanding <= 0;
			failures <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_ITER:    view.max_iterations = cfg_wdata[ITER_W-1:0];
					REG_CUBIC:       view.cubic_mode     = cfg_wdata[0];
					REG_REAL_ORIGIN: view.real_origin    = cfg_wdata;
					REG_IMAG_ORIGIN: view.imag_origin    = cfg_wdata;
					REG_REAL_STEP:   view.real_step      = cfg_wdata[STEP_W-1:0];
					REG_IMAG_STEP:   view.imag_step      = cfg_wdata[STEP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				incoming.column = pixel_column;
				incoming.row    = pixel_row;
				incoming.count  = escape_count(view, pixel_column, pixel_row);
				expected_counts.push_back(incoming);
			end
			if (out_valid && out_ready) begin
				if (expected_counts.size() == 0) begin
					error_total++;
					$display("%0t ns: iteration_count expected none, got %0d",
						$time, iteration_count);
				end else begin
					oldest = expected_counts.pop_front();
					checked_total++;
					if (iteration_count !== oldest.count) begin
						error_total++;
						$display("%0t ns: pixel (%0d, %0d) iteration_count expected %0d, got %0d",
							$time, oldest.column, oldest.row, oldest.count, iteration_count);
					end
				end
			end
			outstanding <= expected_counts.size();
			failures <= error_total;
			results_checked <= checked_total;
		end
	end

endmodule

// ===== bench/escape_time_fractal_iterator_tb.sv =====
// Top of the escape-time iterator testbench: clock, reset, pixel and register stimulus, verdict.
module escape_time_fractal_iterator_tb import etf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS    = 850;
	localparam int PRESSURE_HOLD  = 1500;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES   = 64;

	// Indexes past the register file; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [COORD_W-1:0]    pixel_column;
	logic [COORD_W-1:0]    pixel_row;
	logic                  out_valid;
	logic                  out_ready;
	logic [ITER_W-1:0]     iteration_count;

	int outstanding;
	int failures;
	int results_checked;

	int items_sent;
	int settings_loaded;
	int burst_left;
	bit gaps_on;
	bit pressure_req;
	bit pressure_done;
	int quiet_cycles;

	escape_time_fractal_iterator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pixel_column    (pixel_column),
		.pixel_row       (pixel_row),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.iteration_count (iteration_count)
	);

	escape_time_fractal_iterator_checker count_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pixel_column    (pixel_column),
		.pixel_row       (pixel_row),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.iteration_count (iteration_count),
		.outstanding     (outstanding),
		.failures        (failures),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// One register write per clock; the caller lowers the write enable after a batch.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Load a whole view of the plane. Unused upper data bits carry noise.
	task automatic load_view(input logic [ITER_W-1:0] limit, input logic cubic,
		input logic signed [FX_W-1:0] ro, input logic signed [FX_W-1:0] io,
		input logic [STEP_W-1:0] rstep, input logic [STEP_W-1:0] istep);
		write_reg(REG_MAX_ITER, ($urandom() & ~32'hfff) | 32'(limit));
		write_reg(REG_CUBIC, ($urandom() & ~32'h1) | 32'(cubic));
		write_reg(REG_REAL_ORIGIN, ro);
		write_reg(REG_IMAG_ORIGIN, io);
		write_reg(REG_REAL_STEP, {1'($urandom_range(1)), rstep});
		write_reg(REG_IMAG_STEP, {1'($urandom_range(1)), istep});
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	// Offer one pixel word and hold it until the iterator takes it, then maybe pause.
	task automatic send_pixel(input logic [COORD_W-1:0] column, input logic [COORD_W-1:0] row);
		in_valid <= 1'b1;
		pixel_column <= column;
		pixel_row <= row;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		burst_left--;
		if (gaps_on && burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
	endtask

	// Stop offering and wait until every predicted count has come back.
	task automatic finish_phase();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: stall segments of varying density, plus one long hold-off on request.
	initial begin
		int seg_len;
		int pct;
		out_ready <= 1'b0;
		pressure_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (pressure_req && !pressure_done) begin
				out_ready <= 1'b0;
				repeat (PRESSURE_HOLD) @(posedge clk);
				pressure_done = 1'b1;
			end else begin
				seg_len = $urandom_range(10, 300);
				case ($urandom_range(3))
					0: pct = 0;
					1: pct = 30;
					2: pct = 60;
					default: pct = 90;
				endcase
				repeat (seg_len) begin
					out_ready <= ($urandom_range(99) >= pct);
					@(posedge clk);
					if (pressure_req && !pressure_done) break;
				end
			end
		end
	end

	// Watchdog: end the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("escape_time_fractal_iterator regression: fail");
			$finish;
		end
	end

	// Stimulus: directed views first, then random views until the pixel budget is spent.
	initial begin
		int pick;
		int nitems;
		int random_phases;
		logic [ITER_W-1:0] limit;
		logic cubic;
		logic signed [FX_W-1:0] ro;
		logic signed [FX_W-1:0] io;
		logic [STEP_W-1:0] rstep;
		logic [STEP_W-1:0] istep;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;

		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		pixel_column <= '0;
		pixel_row <= '0;
		pressure_req <= 1'b0;
		items_sent = 0;
		settings_loaded = 0;
		quiet_cycles = 0;
		burst_left = 1;
		gaps_on = 1'b0;
		random_phases = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset view: corners of the image and a pixel near the origin.
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd646, 10'd500);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
		finish_phase();

		// Zero limit returns zero whatever the point.
		load_view(12'd0, 1'b0, RST_REAL_ORIGIN, RST_IMAG_ORIGIN, RST_REAL_STEP, RST_IMAG_STEP);
		send_pixel(10'd646, 10'd500);
		send_pixel(10'd1023, 10'd1023);
		finish_phase();

		// Full limit on bounded orbits: c = -0.5 squared, c = 0.25 cubed.
		load_view(12'hfff, 1'b0, -32'sd67108864, 32'sd0, '0, '0);
		send_pixel(10'd1023, 10'd1023);
		finish_phase();
		load_view(12'hfff, 1'b1, 32'sd33554432, 32'sd0, '0, '0);
		send_pixel(10'd0, 10'd1023);
		finish_phase();

		// Point overflow: the mapped point saturates at the top of the word; the views also reach its bottom.
		load_view(12'd20, 1'b1, FX_MAX, FX_MIN, 31'h7fffffff, 31'h7fffffff);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd0, 10'd1023);
		finish_phase();
		load_view(12'd20, 1'b0, FX_MIN, FX_MIN, '0, '0);
		send_pixel(10'd511, 10'd512);
		send_pixel(10'd1023, 10'd0);
		finish_phase();

		// Cubic view of the square from -1.5 - 1.5i spanning three units.
		load_view(12'd60, 1'b1, -32'sd201326592, -32'sd201326592, 31'd393600, 31'd393600);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'd100, 10'd700);
		send_pixel(10'd900, 10'd200);
		send_pixel(10'd0, 10'd0);
		finish_phase();

		// Random views: mostly short limits around the set, some noise views.
		while (items_sent < TOTAL_ITEMS) begin
			pick = $urandom_range(99);
			nitems = $urandom_range(10, 40);
			if (pick < 4) begin
				limit = '0;
			end else if (pick < 80) begin
				limit = ITER_W'($urandom_range(1, 64));
			end else if (pick < 96) begin
				limit = ITER_W'($urandom_range(65, 200));
			end else begin
				limit = ITER_W'($urandom_range(201, 4095));
				nitems = 2;
			end
			cubic = 1'($urandom_range(1));
			if ($urandom_range(99) < 85) begin
				ro = -$urandom_range(0, 335544320);
				io = -$urandom_range(0, 268435456);
				rstep = STEP_W'($urandom_range(0, 1 << 20));
				istep = STEP_W'($urandom_range(0, 1 << 20));
			end else begin
				ro = $urandom();
				io = $urandom();
				rstep = STEP_W'($urandom());
				istep = STEP_W'($urandom());
			end
			gaps_on = ($urandom_range(3) != 0);
			// One view floods the iterator while the receiver holds off.
			if (random_phases == 2) begin
				limit = ITER_W'($urandom_range(1, 16));
				nitems = 30;
				gaps_on = 1'b0;
			end
			load_view(limit, cubic, ro, io, rstep, istep);
			if (random_phases == 2) pressure_req <= 1'b1;
			repeat (nitems) begin
				if ($urandom_range(9) == 0) begin
					column = $urandom_range(1) ? '1 : '0;
					row = $urandom_range(1) ? '1 : '0;
				end else begin
					column = COORD_W'($urandom_range(1023));
					row = COORD_W'($urandom_range(1023));
				end
				send_pixel(column, row);
			end
			finish_phase();
			random_phases++;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d pixels under %0d register views, square and cubic, limits 0 to 4095.",
			items_sent, settings_loaded);
		$display("Checked %0d escape counts, including saturated points and a long output stall.",
			results_checked);
		if (failures == 0 && outstanding == 0) begin
			$display("escape_time_fractal_iterator regression: pass");
		end else begin
			$display("escape_time_fractal_iterator regression: fail");
		end
		$finish;
	end

endmodule
